>>> hw/rtl/bdrm_pkg.sv
// Shared widths, reset values and register indexes for the byte diff run merger.
`default_nettype none

package bdrm_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int OUT_OFFSET_BITS = 48;
    localparam int LENGTH_BITS     = 25;
    localparam int PAGE_POS_BITS   = 24;
    localparam int GAP_BITS        = 16;
    localparam int EQ_BITS         = 17;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 25;

    typedef logic [LENGTH_BITS-1:0]     page_size_t;
    typedef logic [GAP_BITS-1:0]        gap_t;
    typedef logic [PAGE_POS_BITS-1:0]   page_pos_t;
    typedef logic [EQ_BITS-1:0]         eq_count_t;
    typedef logic [LENGTH_BITS-1:0]     length_t;
    typedef logic [OUT_OFFSET_BITS-1:0] out_offset_t;
    typedef logic [BYTE_BITS-1:0]       byte_t;
    typedef logic [CFG_INDEX_BITS-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]   cfg_data_t;

    localparam cfg_index_t REG_PAGE_SIZE = 1'd0;
    localparam cfg_index_t REG_MAX_GAP   = 1'd1;

    localparam page_size_t PAGE_SIZE_RESET = 25'd4096;
    localparam gap_t       MAX_GAP_RESET   = 16'd16;
    localparam page_size_t PAGE_LIMIT      = 25'd16777216;

endpackage

`default_nettype wire

>>> hw/rtl/byte_diff_run_merger.sv
// Top level: merges runs of differing bytes into offset/length difference records.
// Input transactions pass the input register, then the result register, to reach a result transaction.
// One byte pair per cycle unless a result stalls; the compare and counter update are combinational.
// A stalled result holds the result register; the input register takes one more pair behind it.
// Reset clears stream, page and record state and loads page_size 4096 and max_gap 16.
`default_nettype none

module byte_diff_run_merger #(
    parameter int OFFSET_BITS = 48
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  bdrm_pkg::cfg_index_t    cfg_index,
    input  wire  bdrm_pkg::cfg_data_t     cfg_data,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  bdrm_pkg::byte_t         old_byte,
    input  wire  bdrm_pkg::byte_t         new_byte,
    input  wire                           last,
    output logic                          out_valid,
    input  wire                           out_ready,
    output bdrm_pkg::out_offset_t         diff_offset,
    output bdrm_pkg::length_t             diff_length
);
    import bdrm_pkg::*;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    page_size_t  page_size_reg;
    gap_t        max_gap_reg;

    logic        in_valid_reg;
    byte_t       old_byte_reg;
    byte_t       new_byte_reg;
    logic        last_reg;

    offset_t     stream_pos_reg, stream_pos_next;
    page_pos_t   page_pos_reg, page_pos_next;
    logic        open_reg, open_next;
    offset_t     begin_reg, begin_next;
    offset_t     stop_reg, stop_next;
    eq_count_t   eq_count_reg, eq_count_next;

    logic        out_valid_reg, out_valid_next;
    out_offset_t diff_offset_reg;
    length_t     diff_length_reg;

    logic        advance;
    logic        differ;
    logic        emit;
    offset_t     pos_inc;
    page_size_t  page_pos_inc;
    page_size_t  eff_page_size;
    logic        page_end;
    logic [63:0] begin_ext;
    length_t     length_calc;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg <= PAGE_SIZE_RESET;
            max_gap_reg   <= MAX_GAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PAGE_SIZE: page_size_reg <= cfg_data;
                REG_MAX_GAP:   max_gap_reg   <= cfg_data[GAP_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            old_byte_reg <= old_byte;
            new_byte_reg <= new_byte;
            last_reg     <= last;
        end
    end

    always_comb
    begin
        if (page_size_reg == '0)
        begin
            eff_page_size = 25'd1;
        end
        else if (page_size_reg > PAGE_LIMIT)
        begin
            eff_page_size = PAGE_LIMIT;
        end
        else
        begin
            eff_page_size = page_size_reg;
        end
    end

    assign differ       = old_byte_reg != new_byte_reg;
    assign pos_inc      = stream_pos_reg + offset_t'(1);
    assign page_pos_inc = {1'b0, page_pos_reg} + page_size_t'(1);
    assign page_end     = page_pos_inc >= eff_page_size;

    always_comb
    begin
        open_next     = open_reg;
        begin_next    = begin_reg;
        stop_next     = stop_reg;
        eq_count_next = eq_count_reg;
        emit          = 1'b0;
        if (differ)
        begin
            if (!open_reg)
            begin
                open_next  = 1'b1;
                begin_next = stream_pos_reg;
            end
            stop_next     = pos_inc;
            eq_count_next = '0;
        end
        else if (open_reg)
        begin
            eq_count_next = eq_count_reg + eq_count_t'(1);
            if (eq_count_reg >= {1'b0, max_gap_reg})
            begin
                emit          = 1'b1;
                open_next     = 1'b0;
                eq_count_next = '0;
            end
        end
        if ((page_end || last_reg) && open_next)
        begin
            emit          = 1'b1;
            open_next     = 1'b0;
            eq_count_next = '0;
        end
        if (last_reg)
        begin
            stream_pos_next = '0;
            page_pos_next   = '0;
        end
        else
        begin
            stream_pos_next = pos_inc;
            page_pos_next   = page_end ? '0 : page_pos_inc[PAGE_POS_BITS-1:0];
        end
    end

    assign begin_ext   = 64'(begin_next);
    assign length_calc = stop_next[LENGTH_BITS-1:0] - begin_next[LENGTH_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_pos_reg <= '0;
            page_pos_reg   <= '0;
            open_reg       <= 1'b0;
            begin_reg      <= '0;
            stop_reg       <= '0;
            eq_count_reg   <= '0;
        end
        else if (advance)
        begin
            stream_pos_reg <= stream_pos_next;
            page_pos_reg   <= page_pos_next;
            open_reg       <= open_next;
            begin_reg      <= begin_next;
            stop_reg       <= stop_next;
            eq_count_reg   <= eq_count_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            diff_offset_reg <= begin_ext[OUT_OFFSET_BITS-1:0];
            diff_length_reg <= length_calc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign diff_offset = diff_offset_reg;
    assign diff_length = diff_length_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bdrm_checker.sv
// Port-level checker for the byte diff run merger and its bind.
`default_nettype none

module bdrm_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          cfg_valid,
    input wire                          cfg_ready,
    input wire bdrm_pkg::cfg_index_t    cfg_index,
    input wire bdrm_pkg::cfg_data_t     cfg_data,
    input wire                          in_valid,
    input wire                          in_ready,
    input wire bdrm_pkg::byte_t         old_byte,
    input wire bdrm_pkg::byte_t         new_byte,
    input wire                          last,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire bdrm_pkg::out_offset_t   diff_offset,
    input wire bdrm_pkg::length_t       diff_length
);
    import bdrm_pkg::*;

    logic unused_ok;
    assign unused_ok = cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data) ^ in_valid
                       ^ (^old_byte) ^ (^new_byte) ^ last;

    // hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(diff_offset) && $stable(diff_length))
        else $error("stalled result changed or dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> diff_length != '0)
        else $error("record of zero length");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> diff_length <= PAGE_LIMIT)
        else $error("record longer than the largest page");

    // an empty result register never back-pressures the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no pending result");

endmodule

bind byte_diff_run_merger bdrm_checker u_bdrm_checker (.*);

`default_nettype wire
